// ----- rtl/core/dht_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the double hash table engine.
package dht_pkg;

	localparam int TABLE_SIZE = 23;
	localparam int STEP_PRIME = 19;

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 31;
	localparam int CODE_W = 2;
	localparam int SLOT_W = 5;

	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int STEP_W     = $clog2(STEP_PRIME + 1);
	localparam int REM_W      = (IDX_W > STEP_W) ? IDX_W : STEP_W;
	localparam int OCC_W      = $clog2(TABLE_SIZE + 1);
	localparam int HASH_STEPS = (KEY_W + 1) / 2;
	localparam int HASH_BITS  = 2 * HASH_STEPS;
	localparam int HASH_CNT_W = $clog2(HASH_STEPS);

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_FIND   = 2'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] OP_NONE   = 2'd3;

	localparam logic [CODE_W-1:0] RES_OK     = 2'd0;
	localparam logic [CODE_W-1:0] RES_NO_KEY = 2'd1;
	localparam logic [CODE_W-1:0] RES_DUP    = 2'd2;
	localparam logic [CODE_W-1:0] RES_FULL   = 2'd3;

	typedef enum logic [1:0] {
		MARK_EMPTY,
		MARK_DELETED,
		MARK_ACTIVE
	} mark_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PREP,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] result_code;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key_echo;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic hash_en;
		logic walk_start;
		logic walk_en;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic hash_last;
		logic skip;
		logic walk_stop;
		logic out_free;
	} sts_t;

	// one radix-4 digit of a running remainder: (4r + d) mod m, with r < m
	function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r,
		input logic [1:0] d, input logic [REM_W+1:0] m);
		logic [REM_W+1:0] v;
		logic [REM_W+1:0] m2;
		v  = {r, d};
		m2 = {m[REM_W:0], 1'b0};
		if (v >= m2) begin
			v = v - m2;
		end
		if (v >= m) begin
			v = v - m;
		end
		return v[REM_W-1:0];
	endfunction

endpackage

// ----- rtl/core/dht_ctrl.sv -----
`timescale 1ns / 1ps
// Control state machine: sequences hashing, probe walk and result handoff.
module dht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dht_pkg::sts_t sts,
	output dht_pkg::cmd_t cmd
);

	dht_pkg::state_t state_q;
	dht_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dht_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dht_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = dht_pkg::ST_HASH;
				end
			end
			dht_pkg::ST_HASH: begin
				priority if (sts.skip) begin
					state_nxt = dht_pkg::ST_FINISH;
				end else if (sts.hash_last) begin
					state_nxt = dht_pkg::ST_PREP;
				end
			end
			dht_pkg::ST_PREP: begin
				state_nxt = dht_pkg::ST_WALK;
			end
			dht_pkg::ST_WALK: begin
				if (sts.walk_stop) begin
					state_nxt = dht_pkg::ST_FINISH;
				end
			end
			dht_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = dht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dht_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			dht_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dht_pkg::ST_HASH: begin
				cmd.hash_en = 1'b1;
			end
			dht_pkg::ST_PREP: begin
				cmd.walk_start = 1'b1;
			end
			dht_pkg::ST_WALK: begin
				cmd.walk_en = 1'b1;
			end
			dht_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/core/dht_dp.sv -----
`timescale 1ns / 1ps
// Datapath: hash remainders, probe walk, slot table, occupancy and output register.
module dht_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  dht_pkg::req_t in_data,
	input  logic          out_ready,
	output logic          out_valid,
	output dht_pkg::rsp_t out_data,
	input  dht_pkg::cmd_t cmd,
	output dht_pkg::sts_t sts
);

	localparam logic [dht_pkg::REM_W+1:0] MOD_TABLE =
		(dht_pkg::REM_W + 2)'(dht_pkg::TABLE_SIZE);
	localparam logic [dht_pkg::REM_W+1:0] MOD_STEP =
		(dht_pkg::REM_W + 2)'(dht_pkg::STEP_PRIME);

	logic [dht_pkg::KEY_W-1:0] keys_q [dht_pkg::TABLE_SIZE];
	dht_pkg::mark_t            marks_q [dht_pkg::TABLE_SIZE];
	logic [dht_pkg::OCC_W-1:0] occ_q;

	logic [dht_pkg::FUNC_W-1:0]     func_q;
	logic [dht_pkg::KEY_W-1:0]      key_q;
	logic                           full_q;
	logic [dht_pkg::HASH_BITS-1:0]  sh_q;
	logic [dht_pkg::HASH_CNT_W-1:0] hcnt_q;
	logic [dht_pkg::REM_W-1:0]      rem_h_q;
	logic [dht_pkg::REM_W-1:0]      rem_s_q;

	logic [dht_pkg::IDX_W-1:0] v_q;
	logic [dht_pkg::IDX_W-1:0] step_q;
	logic [dht_pkg::IDX_W-1:0] i_q;
	logic                      found_q;
	logic [dht_pkg::IDX_W-1:0] found_slot_q;
	logic                      free_q;
	logic [dht_pkg::IDX_W-1:0] free_slot_q;

	logic          out_valid_q;
	dht_pkg::rsp_t out_q;

	logic [1:0]                digit;
	logic [dht_pkg::STEP_W-1:0] step_raw;
	logic [dht_pkg::REM_W+1:0] step_ext;
	logic [dht_pkg::IDX_W:0]   v_sum;
	logic [dht_pkg::IDX_W-1:0] v_next;
	dht_pkg::mark_t            cur_mark;
	logic                      cur_hit;

	logic          do_write;
	logic          do_delete;
	dht_pkg::rsp_t rsp;

	assign digit = sh_q[dht_pkg::HASH_BITS-1 -: 2];

	// step = STEP_PRIME - (key mod STEP_PRIME), folded into the table range
	always_comb begin
		step_raw = dht_pkg::STEP_W'(dht_pkg::STEP_PRIME) - dht_pkg::STEP_W'(rem_s_q);
		step_ext = (dht_pkg::REM_W + 2)'(step_raw);
		if (step_ext >= MOD_TABLE) begin
			step_ext = step_ext - MOD_TABLE;
		end
	end

	always_comb begin
		v_sum = {1'b0, v_q} + {1'b0, step_q};
		if (v_sum >= (dht_pkg::IDX_W + 1)'(dht_pkg::TABLE_SIZE)) begin
			v_sum = v_sum - (dht_pkg::IDX_W + 1)'(dht_pkg::TABLE_SIZE);
		end
		v_next = v_sum[dht_pkg::IDX_W-1:0];
	end

	assign cur_mark = marks_q[v_q];
	assign cur_hit  = (cur_mark == dht_pkg::MARK_ACTIVE) && (keys_q[v_q] == key_q);

	assign sts.hash_last = (hcnt_q == dht_pkg::HASH_CNT_W'(dht_pkg::HASH_STEPS - 1));
	assign sts.skip      = (func_q == dht_pkg::OP_NONE) ||
	                       ((func_q == dht_pkg::OP_INSERT) && full_q);
	assign sts.walk_stop = (cur_mark == dht_pkg::MARK_EMPTY) || cur_hit ||
	                       (i_q == dht_pkg::IDX_W'(dht_pkg::TABLE_SIZE - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// request front end and hashing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_data.func;
			key_q   <= in_data.key;
			full_q  <= (occ_q >= dht_pkg::OCC_W'(dht_pkg::TABLE_SIZE));
			sh_q    <= dht_pkg::HASH_BITS'(in_data.key);
			hcnt_q  <= '0;
			rem_h_q <= '0;
			rem_s_q <= '0;
		end else if (cmd.hash_en) begin
			sh_q    <= {sh_q[dht_pkg::HASH_BITS-3:0], 2'b00};
			hcnt_q  <= hcnt_q + dht_pkg::HASH_CNT_W'(1);
			rem_h_q <= dht_pkg::mod_step(rem_h_q, digit, MOD_TABLE);
			rem_s_q <= dht_pkg::mod_step(rem_s_q, digit, MOD_STEP);
		end
	end

	// probe walk: remembers a key hit and the first slot that is not active
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			v_q    <= dht_pkg::IDX_W'(rem_h_q);
			step_q <= dht_pkg::IDX_W'(step_ext);
			i_q    <= '0;
		end else if (cmd.walk_en) begin
			v_q <= v_next;
			i_q <= i_q + dht_pkg::IDX_W'(1);
			if (cur_hit) begin
				found_slot_q <= v_q;
			end
			if ((cur_mark != dht_pkg::MARK_ACTIVE) && !free_q) begin
				free_slot_q <= v_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load || cmd.walk_start) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.walk_en) begin
			if (cur_hit) begin
				found_q <= 1'b1;
			end
			if (cur_mark != dht_pkg::MARK_ACTIVE) begin
				free_q <= 1'b1;
			end
		end
	end

	always_comb begin
		do_write  = 1'b0;
		do_delete = 1'b0;
		rsp       = '{result_code: dht_pkg::RES_NO_KEY, slot: '0, key_echo: '0};
		unique case (func_q)
			dht_pkg::OP_INSERT: begin
				priority if (full_q) begin
					rsp.result_code = dht_pkg::RES_FULL;
				end else if (found_q) begin
					rsp.result_code = dht_pkg::RES_DUP;
				end else if (free_q) begin
					do_write     = 1'b1;
					rsp.result_code = dht_pkg::RES_OK;
					rsp.slot     = dht_pkg::SLOT_W'(free_slot_q);
					rsp.key_echo = key_q;
				end else begin
					rsp.result_code = dht_pkg::RES_FULL;
				end
			end
			dht_pkg::OP_FIND: begin
				if (found_q) begin
					rsp.result_code = dht_pkg::RES_OK;
					rsp.slot        = dht_pkg::SLOT_W'(found_slot_q);
					rsp.key_echo    = key_q;
				end
			end
			dht_pkg::OP_REMOVE: begin
				if (found_q) begin
					do_delete       = 1'b1;
					rsp.result_code = dht_pkg::RES_OK;
					rsp.slot        = dht_pkg::SLOT_W'(found_slot_q);
					rsp.key_echo    = key_q;
				end
			end
			default: begin
				rsp.result_code = dht_pkg::RES_NO_KEY;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && do_write) begin
			keys_q[free_slot_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < dht_pkg::TABLE_SIZE; n++) begin
				marks_q[n] <= dht_pkg::MARK_EMPTY;
			end
			occ_q <= '0;
		end else if (cmd.finish) begin
			if (do_write) begin
				marks_q[free_slot_q] <= dht_pkg::MARK_ACTIVE;
				occ_q                <= occ_q + dht_pkg::OCC_W'(1);
			end else if (do_delete) begin
				marks_q[found_slot_q] <= dht_pkg::MARK_DELETED;
				if (occ_q != '0) begin
					occ_q <= occ_q - dht_pkg::OCC_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/double_hash_table_engine_top.sv -----
`timescale 1ns / 1ps
// Top level of the double hash table engine.
// Open-addressing table of 23 slots holding 31-bit keys, double hashing.
// Input channel (in_valid/in_ready/in_data): one beat is one request,
// func 0 insert, 1 find, 2 remove, with its key. Output channel
// (out_valid/out_ready/out_data): exactly one result beat per request,
// in request order: result code, slot and key echo.
// Sequence: radix-4 remainder hashing (key mod 23 and
// key mod 19 in parallel), a state to set up the walk, then the walk
// over the probed slots (1 to 23), then a commit; the result is registered
// at the commit. A request that fails at once (unknown func, insert on a
// full table) skips the walk and goes from hashing straight to the commit.
// One request is in flight at a time; the probe walk sets the rate.
// The output register lets a new request be taken while a result waits;
// a stalled receiver holds the next result in its commit cycle.
// Reset empties every slot and clears the occupancy count.
module double_hash_table_engine_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dht_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dht_pkg::rsp_t out_data
);

	dht_pkg::cmd_t cmd;
	dht_pkg::sts_t sts;

	dht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
